@@ hw/rtl/ptc_pkg.sv @@
// Package for the pressure/temperature compensation block.
// Holds pipeline depth, divider width and configuration register indexes.
// No dependencies.
package ptc_pkg;

    localparam int unsigned DIV_BITS  = 32;
    // Stages: 11 before the divider, its input stage, 32 divide steps, 4 after.
    localparam int unsigned PIPE_DEPTH = 16 + DIV_BITS;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_CAL    = 2'd0,
        CFG_PRESS_CAL_A = 2'd1,
        CFG_PRESS_CAL_B = 2'd2,
        CFG_PRESS_CAL_C = 2'd3
    } t_cfg_idx;

endpackage

@@ hw/rtl/pressure_temperature_compensation.sv @@
// Top level of the pressure/temperature compensation pipeline.
// Depends on ptc_pkg.
//
// channel | direction | handshake                  | payload
// input   | in        | i_in_valid / o_in_ready    | i_raw_pressure, i_raw_temperature
// output  | out       | o_out_valid / i_out_ready  | o_temperature_centi, o_pressure_pa,
//         |           |                            | o_pressure_valid
// config  | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One transaction enters per cycle unless the output stalls; results leave in
// input order, and the pipelined unsigned divider works in 32 one-bit steps.
// The whole pipeline advances together; when the output register holds a
// result that is not taken, every stage holds and input is refused.
// Reset clears only the stage valid bits and the calibration registers.
module pressure_temperature_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ptc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [19:0]                   i_raw_pressure,
    input  logic [19:0]                   i_raw_temperature,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [23:0]            o_temperature_centi,
    output logic [31:0]                   o_pressure_pa,
    output logic                          o_pressure_valid
);
    import ptc_pkg::*;

    localparam int unsigned NS = PIPE_DEPTH;
    localparam int unsigned DS = 11;            // divider input stage
    localparam int unsigned DE = DS + DIV_BITS; // last divide step

    // calibration registers
    logic [47:0] r_temp_cal;
    logic [63:0] r_press_a;
    logic [63:0] r_press_b;
    logic [15:0] r_press_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal <= '0;
            r_press_a  <= '0;
            r_press_b  <= '0;
            r_press_c  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TEMP_CAL:    r_temp_cal <= i_cfg_data[47:0];
                CFG_PRESS_CAL_A: r_press_a  <= i_cfg_data;
                CFG_PRESS_CAL_B: r_press_b  <= i_cfg_data;
                CFG_PRESS_CAL_C: r_press_c  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // extend calibration words to 32 bits
    logic [31:0] w_t1, w_t2, w_t3, w_p1, w_p2, w_p3, w_p4;
    logic [31:0] w_p5, w_p6, w_p7, w_p8, w_p9;
    assign w_t1 = {16'd0, r_temp_cal[15:0]};
    assign w_t2 = {{16{r_temp_cal[31]}}, r_temp_cal[31:16]};
    assign w_t3 = {{16{r_temp_cal[47]}}, r_temp_cal[47:32]};
    assign w_p1 = {16'd0, r_press_a[15:0]};
    assign w_p2 = {{16{r_press_a[31]}}, r_press_a[31:16]};
    assign w_p3 = {{16{r_press_a[47]}}, r_press_a[47:32]};
    assign w_p4 = {{16{r_press_a[63]}}, r_press_a[63:48]};
    assign w_p5 = {{16{r_press_b[15]}}, r_press_b[15:0]};
    assign w_p6 = {{16{r_press_b[31]}}, r_press_b[31:16]};
    assign w_p7 = {{16{r_press_b[47]}}, r_press_b[47:32]};
    assign w_p8 = {{16{r_press_b[63]}}, r_press_b[63:48]};
    assign w_p9 = {{16{r_press_c[15]}}, r_press_c};

    // global advance: hold everything while the output is stalled
    logic w_adv;
    logic [NS-1:0] r_v;
    assign w_adv       = !r_v[NS-1] || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NS-2:0], i_in_valid};
        end
    end

    // stage payload registers
    logic [31:0] r0_x1, r0_d;
    logic [31:0] r1_m1, r1_dd;
    logic [31:0] r2_a, r2_m2;
    logic [31:0] r3_fine;
    logic [31:0] r4_pa;
    logic [31:0] r5_sq, r5_m5, r5_m2p;
    logic [31:0] r6_b1, r6_m3, r6_m5, r6_m2p;
    logic [31:0] r7_b, r7_s;
    logic [31:0] r8_den, r8_b;
    logic [31:0] r9_div, r9_num;
    logic [31:0] r10_pm, r10_div;
    logic [31:0] r44_p;
    logic [31:0] r45_ma, r45_mb, r45_p;
    logic [31:0] r46_mc, r46_mb, r46_p;
    logic [31:0] r47_p;
    logic [19:0] r_ap  [0:8];
    logic [31:0] r_tmp [4:NS-1];
    logic        r_ok  [DS:NS-1];
    logic        r_shf [DS:DE];
    logic [31:0] r_dv  [DS:DE];
    logic [31:0] r_rem [DS:DE];
    logic [31:0] r_nq  [DS:DE];

    // combinational helpers
    logic [31:0] n_x1, n_d, n_fine5, n_pa, n_q, n_sq11, n_sq13;
    logic [31:0] n_b, n_a, n_den15, n_pmin, n_num, n_sqs, n_aa, n_bb, n_sum;
    logic [32:0] n_rsh [DS:DE-1];
    logic [32:0] n_rdf [DS:DE-1];

    always_comb begin
        n_x1    = {15'd0, i_raw_temperature[19:3]} - {w_t1[30:0], 1'b0};
        n_d     = {16'd0, i_raw_temperature[19:4]} - w_t1;
        n_fine5 = {r3_fine[29:0], 2'b00} + r3_fine + 32'd128;
        n_pa    = 32'($signed(r3_fine) >>> 1) - 32'd64000;
        n_q     = 32'($signed(r4_pa) >>> 2);
        n_sq11  = 32'($signed(r5_sq) >>> 11);
        n_sq13  = 32'($signed(r5_sq) >>> 13);
        n_b     = 32'($signed(r6_b1 + {r6_m5[30:0], 1'b0}) >>> 2) + {w_p4[15:0], 16'd0};
        n_a     = 32'($signed(32'($signed(r6_m3) >>> 3) + 32'($signed(r6_m2p) >>> 1)) >>> 18);
        n_den15 = 32'($signed(r8_den) >>> 15);
        n_num   = (32'd1048576 - {12'd0, r_ap[8]}) - 32'($signed(r8_b) >>> 12);
        n_pmin  = r10_pm;
        n_sqs   = {13'd0, r45_ma[31:13]};
        n_aa    = 32'($signed(r46_mc) >>> 12);
        n_bb    = 32'($signed(r46_mb) >>> 13);
        n_sum   = r46_p + 32'($signed(n_aa + n_bb + w_p7) >>> 4);
        // one restoring divide step per stage
        for (int k = DS; k < DE; k++) begin
            n_rsh[k] = {r_rem[k], r_nq[k][31]};
            n_rdf[k] = n_rsh[k] - {1'b0, r_dv[k]};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_x1  <= n_x1;
            r0_d   <= n_d;
            r_ap[0] <= i_raw_pressure;
            for (int k = 1; k < 9; k++) r_ap[k] <= r_ap[k-1];

            r1_m1 <= r0_x1 * w_t2;
            r1_dd <= r0_d * r0_d;

            r2_a  <= 32'($signed(r1_m1) >>> 11);
            r2_m2 <= 32'($signed(r1_dd) >>> 12) * w_t3;

            r3_fine <= r2_a + 32'($signed(r2_m2) >>> 14);

            r_tmp[4] <= 32'($signed(n_fine5) >>> 8);
            r4_pa    <= n_pa;
            for (int k = 5; k < NS; k++) r_tmp[k] <= r_tmp[k-1];

            r5_sq  <= n_q * n_q;
            r5_m5  <= r4_pa * w_p5;
            r5_m2p <= w_p2 * r4_pa;

            r6_b1  <= n_sq11 * w_p6;
            r6_m3  <= w_p3 * n_sq13;
            r6_m5  <= r5_m5;
            r6_m2p <= r5_m2p;

            r7_b <= n_b;
            r7_s <= 32'd32768 + n_a;

            r8_den <= r7_s * w_p1;
            r8_b   <= r7_b;

            r9_div <= n_den15;
            r9_num <= n_num;

            r10_pm  <= r9_num * 32'd3125;
            r10_div <= r9_div;

            // divider input: pick pre- or post-shift form
            r_ok[DS]  <= (r10_div != 32'd0);
            r_shf[DS] <= n_pmin[31];
            r_dv[DS]  <= r10_div;
            r_rem[DS] <= '0;
            r_nq[DS]  <= n_pmin[31] ? n_pmin : {n_pmin[30:0], 1'b0};
            for (int k = DS; k < DE; k++) begin
                r_ok[k+1]  <= r_ok[k];
                r_shf[k+1] <= r_shf[k];
                r_dv[k+1]  <= r_dv[k];
                if (!n_rdf[k][32]) begin
                    r_rem[k+1] <= n_rdf[k][31:0];
                    r_nq[k+1]  <= {r_nq[k][30:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_rsh[k][31:0];
                    r_nq[k+1]  <= {r_nq[k][30:0], 1'b0};
                end
            end
            for (int k = DE + 1; k < NS; k++) r_ok[k] <= r_ok[k-1];

            r44_p <= r_shf[DE] ? {r_nq[DE][30:0], 1'b0} : r_nq[DE];

            r45_ma <= {3'd0, r44_p[31:3]} * {3'd0, r44_p[31:3]};
            r45_mb <= {2'd0, r44_p[31:2]} * w_p8;
            r45_p  <= r44_p;

            r46_mc <= w_p9 * n_sqs;
            r46_mb <= r45_mb;
            r46_p  <= r45_p;

            r47_p <= r_ok[NS-2] ? n_sum : 32'd0;
        end
    end

    assign o_temperature_centi = r_tmp[NS-1][23:0];
    assign o_pressure_pa       = r47_p;
    assign o_pressure_valid    = r_ok[NS-1];

endmodule

@@ hw/rtl/ptc_checker.sv @@
// Port-level checker for the compensation pipeline, bound to the top level.
// Depends on ptc_pkg and pressure_temperature_compensation.
module ptc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_pressure_pa,
    input logic        o_pressure_valid
);
    import ptc_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // input is taken exactly when the output side can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // invalid pressure reads as zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pressure_valid |-> o_pressure_pa == 32'd0)
        else $error("nonzero pressure with divisor zero");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_pressure_pa    (o_pressure_pa),
    .o_pressure_valid (o_pressure_valid)
);

@@ test/pressure_temperature_compensation_tb.sv @@
// Testbench for the pressure/temperature compensation pipeline.
// Predicts each reading pair with a 32-bit integer model and checks results in order.
// Depends on ptc_pkg and pressure_temperature_compensation.
module pressure_temperature_compensation_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ptc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES   = PIPE_DEPTH + 8;
    localparam int unsigned RANDOM_ITEMS   = 600;

    typedef struct packed {
        logic [23:0] temp_centi;
        logic [31:0] press_pa;
        logic        press_ok;
    } t_comp_result;

    typedef struct {
        logic [19:0]  raw_p;
        logic [19:0]  raw_t;
        bit           has_fixed;
        t_comp_result fixed;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic [19:0] i_raw_pressure;
    logic [19:0] i_raw_temperature;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [23:0] o_temperature_centi;
    logic [31:0] o_pressure_pa;
    logic o_pressure_valid;

    // calibration copy
    logic [47:0] cal_temp;
    logic [63:0] cal_pa;
    logic [63:0] cal_pb;
    logic [15:0] cal_pc;

    t_comp_result pending_results[$];
    int unsigned  fail_count;
    int unsigned  idle_cycles;
    bit           rx_stall_ok;

    pressure_temperature_compensation u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] asr(logic [31:0] x, int s);
        return $unsigned($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] sext16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic t_comp_result compensate(logic [19:0] adc_p, logic [19:0] adc_t);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, d, fine, temp, sq, p;
        logic [31:0] ap, at;
        t_comp_result r;
        ap = {12'd0, adc_p};
        at = {12'd0, adc_t};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = sext16(cal_temp[31:16]);
        t3 = sext16(cal_temp[47:32]);
        p1 = {16'd0, cal_pa[15:0]};
        p2 = sext16(cal_pa[31:16]);
        p3 = sext16(cal_pa[47:32]);
        p4 = sext16(cal_pa[63:48]);
        p5 = sext16(cal_pb[15:0]);
        p6 = sext16(cal_pb[31:16]);
        p7 = sext16(cal_pb[47:32]);
        p8 = sext16(cal_pb[63:48]);
        p9 = sext16(cal_pc);
        // fine temperature
        a = asr(((at >> 3) - (t1 << 1)) * t2, 11);
        d = (at >> 4) - t1;
        b = asr(asr(d * d, 12) * t3, 14);
        fine = a + b;
        temp = asr(fine * 32'd5 + 32'd128, 8);
        // pressure
        a = asr(fine, 1) - 32'd64000;
        sq = asr(a, 2) * asr(a, 2);
        b = asr(sq, 11) * p6;
        b = b + ((a * p5) << 1);
        b = asr(b, 2) + (p4 << 16);
        a = asr(asr(p3 * asr(sq, 13), 3) + asr(p2 * a, 1), 18);
        a = asr((32'd32768 + a) * p1, 15);
        p = 32'd0;
        r.press_ok = (a != 32'd0);
        if (r.press_ok) begin
            p = ((32'd1048576 - ap) - asr(b, 12)) * 32'd3125;
            if (p < 32'h8000_0000) p = (p << 1) / a;
            else p = (p / a) << 1;
            sq = ((p >> 3) * (p >> 3)) >> 13;
            a = asr(p9 * sq, 12);
            b = asr((p >> 2) * p8, 13);
            p = p + asr(a + b + p7, 4);
        end
        r.temp_centi = temp[23:0];
        r.press_pa = p;
        return r;
    endfunction

    // write one calibration register while idle
    task automatic write_cal(t_cfg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_TEMP_CAL:    cal_temp = val[47:0];
            CFG_PRESS_CAL_A: cal_pa = val;
            CFG_PRESS_CAL_B: cal_pb = val;
            default:         cal_pc = val[15:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_cal(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                            logic [15:0] pc);
        write_cal(CFG_TEMP_CAL, {16'd0, tc});
        write_cal(CFG_PRESS_CAL_A, pa);
        write_cal(CFG_PRESS_CAL_B, pb);
        write_cal(CFG_PRESS_CAL_C, {48'd0, pc});
    endtask

    // drop valid and wait until every result is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // present one transaction and hold it until accepted
    task automatic send_pair(logic [19:0] rp, logic [19:0] rt, bit has_fixed,
                             t_comp_result fixed, bit use_gaps);
        t_comp_result exp_r;
        int unsigned  gap;
        gap = use_gaps ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        exp_r = has_fixed ? fixed : compensate(rp, rt);
        i_in_valid        <= 1'b1;
        i_raw_pressure    <= rp;
        i_raw_temperature <= rt;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(exp_r);
    endtask

    // typical datasheet-style calibration
    localparam logic [47:0] CAL_T_TYP  = {16'hFC18, 16'h6810, 16'h6E05};
    localparam logic [63:0] CAL_PA_TYP = {16'h1F32, 16'h0BD0, 16'hD658, 16'h8E66};
    localparam logic [63:0] CAL_PB_TYP = {16'hCFF5, 16'h0F40, 16'hFFF9, 16'h0007};
    localparam logic [15:0] CAL_PC_TYP = 16'h1770;

    t_stim_row rows[$];

    // receive side: random stall once enabled, compare on acceptance
    always @(posedge i_clk) begin
        t_comp_result exp_r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no expectation waiting");
                    fail_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (o_temperature_centi !== exp_r.temp_centi) begin
                        $error("temperature_centi exp %0h got %0h",
                               exp_r.temp_centi, o_temperature_centi);
                        fail_count++;
                    end
                    if (o_pressure_pa !== exp_r.press_pa) begin
                        $error("pressure_pa exp %0h got %0h", exp_r.press_pa, o_pressure_pa);
                        fail_count++;
                    end
                    if (o_pressure_valid !== exp_r.press_ok) begin
                        $error("pressure_valid exp %0b got %0b",
                               exp_r.press_ok, o_pressure_valid);
                        fail_count++;
                    end
                end
            end
            i_out_ready <= rx_stall_ok ? ($urandom_range(0, 99) < 75) : 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** pressure_temperature_compensation: FAILED **");
            $finish;
        end
    end

    initial begin
        t_comp_result zero_r;
        t_comp_result none_r;
        logic [19:0] rp, rt;
        int unsigned k;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_TEMP_CAL;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_raw_pressure = '0;
        i_raw_temperature = '0;
        i_out_ready = 1'b1;
        cal_temp = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0;
        fail_count = 0;
        idle_cycles = 0;
        rx_stall_ok = 0;
        none_r = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset all calibration is zero: fine = 0, temp = 0, divisor zero
        zero_r = '0;
        rows.push_back('{20'h00000, 20'h00000, 1'b1, zero_r});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b0, none_r});
        rows.push_back('{20'hFFFFF, 20'h00000, 1'b0, none_r});
        foreach (rows[i]) send_pair(rows[i].raw_p, rows[i].raw_t, rows[i].has_fixed,
                                    rows[i].fixed, 1'b0);
        wait_drained();
        rows.delete();

        // typical calibration, then field extremes and single bits
        load_cal(CAL_T_TYP, CAL_PA_TYP, CAL_PB_TYP, CAL_PC_TYP);
        rows.push_back('{20'h00000, 20'h00000, 1'b0, none_r});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b0, none_r});
        rows.push_back('{20'h65A00, 20'h7E700, 1'b0, none_r});
        rows.push_back('{20'h80000, 20'h80000, 1'b0, none_r});
        rows.push_back('{20'h00001, 20'h00001, 1'b0, none_r});
        rows.push_back('{20'h7FFFF, 20'h7FFFF, 1'b0, none_r});
        rows.push_back('{20'hAAAAA, 20'h55555, 1'b0, none_r});
        rows.push_back('{20'h55555, 20'hAAAAA, 1'b0, none_r});
        foreach (rows[i]) send_pair(rows[i].raw_p, rows[i].raw_t, rows[i].has_fixed,
                                    rows[i].fixed, 1'b0);
        wait_drained();
        rows.delete();

        // all-ones calibration: extreme wrap, P1 large
        load_cal('1, '1, '1, '1);
        for (k = 0; k < 6; k++)
            send_pair(20'($urandom), 20'($urandom), 1'b0, none_r, 1'b0);
        wait_drained();
        // P1 zero only: divisor zero case with live temperature
        load_cal(CAL_T_TYP, {CAL_PA_TYP[63:16], 16'h0000}, CAL_PB_TYP, CAL_PC_TYP);
        for (k = 0; k < 4; k++)
            send_pair(20'($urandom), 20'($urandom), 1'b0, none_r, 1'b0);
        wait_drained();
        // most negative signed words
        load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                 {4{16'h8000}}, 16'h8000);
        for (k = 0; k < 4; k++)
            send_pair(20'($urandom), 20'($urandom), 1'b0, none_r, 1'b0);
        wait_drained();

        // random phases with different calibration
        rx_stall_ok = 1;
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 0 || ph == 3)
                load_cal(CAL_T_TYP, CAL_PA_TYP, CAL_PB_TYP, CAL_PC_TYP);
            else
                load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                         {$urandom, $urandom}, 16'($urandom));
            for (k = 0; k < RANDOM_ITEMS / 6; k++) begin
                if ($urandom_range(0, 3) != 0) begin
                    rp = 20'($urandom_range(20'h40000, 20'hA0000));
                    rt = 20'($urandom_range(20'h60000, 20'h90000));
                end else begin
                    rp = 20'($urandom);
                    rt = 20'($urandom);
                end
                send_pair(rp, rt, 1'b0, none_r, 1'b1);
                // hold the sender until the pipeline has emptied
                if (k == 40) begin
                    i_in_valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
            end
            wait_drained();
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("** pressure_temperature_compensation: PASSED **");
        else
            $display("** pressure_temperature_compensation: FAILED **");
        $finish;
    end

endmodule
